// File: design/bf3_pkg.sv
package bf3_pkg;

	// Default line and frame limits
	localparam int MAX_COLS_DEF = 2048;
	localparam int MAX_ROWS_DEF = 2048;

	// Register file
	localparam int DIM_W = 12;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// action codes
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_PAD   = 1'b1;

	// 3x3 sum of 8-bit samples, at most 2295
	localparam int SUM_W = 12;

	// floor(x/9) == (x*7282) >> 16 for x <= 2295
	localparam int DIV9_W = 13;
	localparam int DIV9_SHIFT = 16;
	localparam logic [DIV9_W-1:0] DIV9_MUL = 13'd7282;

	localparam int FIFO_DEPTH = 8;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// one line memory entry: pixel one row up and two rows up
	typedef struct packed {
		rgb_t prev1;
		rgb_t prev2;
	} line_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} result_t;

	// per-position control carried down the pipe
	typedef struct packed {
		logic emit;
		logic last;
		logic top;
		logic bottom;
		logic left;
		logic right;
	} tap_ctl_t;

	function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
		logic [SUM_W+DIV9_W-1:0] prod;
		prod = {{DIV9_W{1'b0}}, s} * {{SUM_W{1'b0}}, DIV9_MUL};
		return prod[DIV9_SHIFT+7:DIV9_SHIFT];
	endfunction

endpackage

// File: design/box_filter_3x3_rgb.sv
// 3x3 box mean over an RGB raster stream, one word per clock while the output queue has room.
// The mean of pixel p follows the word at position p+width+1 through the pipe into
// the output queue; width+1 pad words after the last pixel flush the frame.
// Rate is set by the line memory: one read and one write of a 48-bit entry
// per cycle. Async active-low reset clears counters, pipe and output queue and
// loads 640x480; the line memory is not cleared (stale entries are masked).
module box_filter_3x3_rgb #(
	parameter int MAX_COLS = bf3_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = bf3_pkg::MAX_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel words in
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic        action,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	// result words out
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        last_pixel
);
	import bf3_pkg::*;

	localparam int CW = $clog2(MAX_COLS);
	// rows run to height+1 while the last row is flushed
	localparam int RW = $clog2(MAX_ROWS + 2);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int CRD_W = $clog2(FIFO_DEPTH + 4);

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_HEIGHT) begin
				height_q <= pwdata[DIM_W-1:0];
			end else begin
				width_q <= pwdata[DIM_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WIDTH) begin
			prdata[DIM_W-1:0] = width_q;
		end else begin
			prdata[DIM_W-1:0] = height_q;
		end
	end

	// Effective last column / last row: 0 behaves as 1, large values clamp
	logic [CW-1:0] w_last;
	logic [RW-1:0] h_last;

	always_comb begin
		if (width_q == '0) begin
			w_last = '0;
		end else if (32'(width_q) > MAX_COLS) begin
			w_last = CW'(MAX_COLS - 1);
		end else begin
			w_last = CW'(width_q - 1'b1);
		end
		if (height_q == '0) begin
			h_last = '0;
		end else if (32'(height_q) > MAX_ROWS) begin
			h_last = RW'(MAX_ROWS - 1);
		end else begin
			h_last = RW'(height_q - 1'b1);
		end
	end

	// ---------------------------------------------------------------
	// Position tracking at the input
	// col/row: raster position of the incoming word (runs past the frame
	// during the flush). pc/pr: position of the next mean to be produced.
	// primed: width+1 positions have gone in, each new one yields a mean.
	// ---------------------------------------------------------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] pc_q;
	logic [RW-1:0] pr_q;
	logic          primed_q;

	logic     take;
	logic     in_image;
	logic     advance;
	logic     emit;
	logic     last;
	rgb_t     pix;
	tap_ctl_t ctl;

	assign take = pixel_valid && pixel_ready;
	assign in_image = (row_q <= h_last);
	// a pad word inside the frame is a bubble; data past the frame is padding
	assign advance = take && !(in_image && (action == ACT_PAD));
	assign emit = primed_q;
	assign last = emit && (pr_q == h_last) && (pc_q == w_last);

	always_comb begin
		pix = '0;
		if (in_image) begin
			pix = '{r: red_in, g: green_in, b: blue_in};
		end
		ctl = '{
			emit:   emit,
			last:   last,
			top:    (pr_q == '0),
			bottom: (pr_q == h_last),
			left:   (pc_q == '0),
			right:  (pc_q == w_last)
		};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pc_q <= '0;
			pr_q <= '0;
			primed_q <= 1'b0;
		end else if (cfg_wr || (advance && last)) begin
			col_q <= '0;
			row_q <= '0;
			pc_q <= '0;
			pr_q <= '0;
			primed_q <= 1'b0;
		end else if (advance) begin
			if (col_q == w_last) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
			// position == width: the next one centers on pixel 0
			if ((row_q == RW'(1)) && (col_q == '0)) begin
				primed_q <= 1'b1;
			end
			if (emit) begin
				if (pc_q == w_last) begin
					pc_q <= '0;
					pr_q <= pr_q + 1'b1;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: line memory read returns, write back shifted rows,
	// shift the 3x3 window
	// ---------------------------------------------------------------
	logic          valid_s1;
	logic [CW-1:0] col_s1;
	rgb_t          pix_s1;
	tap_ctl_t      ctl_s1;
	line_word_t    lm_rd;
	line_word_t    lm_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			col_s1 <= col_q;
			pix_s1 <= pix;
			ctl_s1 <= ctl;
		end
	end

	assign lm_wr = '{prev1: pix_s1, prev2: lm_rd.prev1};

	bf3_line_mem #(
		.DEPTH(MAX_COLS),
		.AW(CW)
	) u_line_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(advance),
		.rd_addr(col_q),
		.wr_en(valid_s1),
		.wr_addr(col_s1),
		.wr_data(lm_wr),
		.rd_data(lm_rd)
	);

	// win_q[col][row]: col 0 oldest (left), row 0 two lines up (top)
	rgb_t win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= '0;
				end
			end
		end else if (valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[0][r] <= win_q[1][r];
				win_q[1][r] <= win_q[2][r];
			end
			win_q[2][0] <= lm_rd.prev2;
			win_q[2][1] <= lm_rd.prev1;
			win_q[2][2] <= pix_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: masked 3x3 sums
	// ---------------------------------------------------------------
	logic             valid_s2;
	tap_ctl_t         ctl_s2;
	logic [SUM_W-1:0] sum_r;
	logic [SUM_W-1:0] sum_g;
	logic [SUM_W-1:0] sum_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_comb begin
		logic keep;
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		keep = 1'b0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				// taps outside the frame count as zero
				keep = !((r == 0) && ctl_s2.top) && !((r == 2) && ctl_s2.bottom) &&
					!((c == 0) && ctl_s2.left) && !((c == 2) && ctl_s2.right);
				if (keep) begin
					sum_r = sum_r + SUM_W'(win_q[c][r].r);
					sum_g = sum_g + SUM_W'(win_q[c][r].g);
					sum_b = sum_b + SUM_W'(win_q[c][r].b);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: divide by 9 (reciprocal multiply) into the output queue
	// ---------------------------------------------------------------
	logic             valid_s3;
	logic             last_s3;
	logic [SUM_W-1:0] sum_r_s3;
	logic [SUM_W-1:0] sum_g_s3;
	logic [SUM_W-1:0] sum_b_s3;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			sum_r_s3 <= sum_r;
			sum_g_s3 <= sum_g;
			sum_b_s3 <= sum_b;
			last_s3 <= ctl_s2.last;
		end
	end

	assign res = '{
		red:   div9(sum_r_s3),
		green: div9(sum_g_s3),
		blue:  div9(sum_b_s3),
		last:  last_s3
	};

	// ---------------------------------------------------------------
	// Output queue; input is held off when queued plus in-flight means
	// would overrun it
	// ---------------------------------------------------------------
	logic             q_pop;
	logic [CNT_W-1:0] q_count;
	logic [CRD_W-1:0] credit;
	result_t          q_out;

	assign q_pop = result_valid && result_ready;

	bf3_out_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(valid_s3),
		.push_data(res),
		.pop(q_pop),
		.out_valid(result_valid),
		.out_data(q_out),
		.count(q_count)
	);

	assign credit = CRD_W'(q_count) + CRD_W'(valid_s1 && ctl_s1.emit) +
		CRD_W'(valid_s2) + CRD_W'(valid_s3);
	assign pixel_ready = (credit < CRD_W'(FIFO_DEPTH));

	assign red_out = q_out.red;
	assign green_out = q_out.green;
	assign blue_out = q_out.blue;
	assign last_pixel = q_out.last;

endmodule

// File: design/bf3_line_mem.sv
module bf3_line_mem #(
	parameter int DEPTH = bf3_pkg::MAX_COLS_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  bf3_pkg::line_word_t wr_data,
	output bf3_pkg::line_word_t rd_data
);
	import bf3_pkg::*;

	line_word_t mem [DEPTH];
	line_word_t rd_q;
	line_word_t fwd_data_q;
	logic       fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// read and write of the same entry in one cycle: take the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

// File: design/bf3_out_fifo.sv
module bf3_out_fifo #(
	parameter int DEPTH = bf3_pkg::FIFO_DEPTH,
	parameter int PW = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bf3_pkg::result_t push_data,
	input  logic             pop,
	output logic             out_valid,
	output bf3_pkg::result_t out_data,
	output logic [CNT_W-1:0] count
);
	import bf3_pkg::*;

	result_t          buf_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign out_valid = (count_q != '0);
	assign out_data = buf_q[rd_ptr_q];
	assign count = count_q;

endmodule

// File: design/bf3_checker.sv
module bf3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pixel_valid,
	input logic        pixel_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [7:0]  red_out,
	input logic [7:0]  green_out,
	input logic [7:0]  blue_out,
	input logic        last_pixel
);

	// stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable({red_out, green_out, blue_out, last_pixel}))
		else $error("result word dropped or changed while stalled");

	// an empty output side can only wake up from an input word taken earlier and carried through the pipe into the queue
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(pixel_valid && pixel_ready, 4))
		else $error("result appeared without a matching input word");

	// register write is visible to a read of the same address next cycle
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) ##1 (psel && !pwrite && (paddr[2] == $past(paddr[2]))) |->
			(prdata[11:0] == $past(pwdata[11:0])))
		else $error("register readback mismatch");

endmodule

bind box_filter_3x3_rgb bf3_checker u_bf3_checker (.*);
